FILE: hw/rtl/ptw_pkg.sv
// Shared types, constants and codes for the translation table walker.
package ptw_pkg;

  localparam int VA_W           = 64;
  localparam int PA_W           = 48;
  localparam int PAGE_SHIFT     = 12;
  localparam int INDEX_BITS     = 9;
  localparam int ENTRY_SHIFT    = 3;
  localparam int PN_W           = PA_W - PAGE_SHIFT;
  localparam int LEVEL_W        = 3;
  localparam int DEFAULT_LEVELS = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int ATTR_W         = 2;

  localparam int DESC_VALID_BIT = 0;
  localparam int DESC_TABLE_BIT = 1;
  localparam int DESC_XN_LSB    = 53;
  localparam int DESC_SH_LSB    = 8;
  localparam int DESC_AP_RW_BIT = 7;
  localparam int DESC_AP_EL_BIT = 6;
  localparam int DESC_ATTR_LSB  = 2;

  localparam logic [PA_W-1:0] ROOT_RESET        = '0;
  localparam logic [VA_W-1:0] REGION_BASE_RESET = '0;
  localparam logic [VA_W-1:0] REGION_MASK_RESET = 64'hFFFF_0000_0000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROOT_TABLE  = 2'd0,
    CFG_REGION_BASE = 2'd1,
    CFG_REGION_MASK = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ITEM_LOOKUP        = 1'b0,
    ITEM_READ_RESPONSE = 1'b1
  } item_kind_e;

  typedef enum logic {
    RESULT_READ_REQUEST = 1'b0,
    RESULT_LOOKUP_DONE  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE          = 2'd0,
    FAULT_BAD_ADDRESS   = 2'd1,
    FAULT_INVALID_ENTRY = 2'd2,
    FAULT_READ_ERROR    = 2'd3
  } fault_e;

  typedef struct packed {
    logic [PA_W-1:0] root_table_address;
    logic [VA_W-1:0] region_base;
    logic [VA_W-1:0] region_mask;
  } cfg_t;

  typedef struct packed {
    item_kind_e      kind;
    logic [VA_W-1:0] virtual_address;
    logic [VA_W-1:0] read_data;
    logic            read_error;
  } item_t;

  typedef struct packed {
    result_kind_e           kind;
    logic [PA_W-1:0]        entry_address;
    logic                   found;
    fault_e                 fault_reason;
    logic [LEVEL_W-1:0]     final_level;
    logic [INDEX_BITS-1:0]  table_index;
    logic [PA_W-1:0]        output_address;
    logic [ATTR_W-1:0]      exec_permission;
    logic [ATTR_W-1:0]      shareability;
    logic                   write_permission;
    logic                   user_access;
    logic [ATTR_W-1:0]      memory_type;
  } result_t;

endpackage

FILE: hw/rtl/ptw_cfg_regs.sv
// Configuration registers of the table walker: root table, region base and mask.
module ptw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptw_pkg::VA_W-1:0]         cfg_data,
  output ptw_pkg::cfg_t                    cfg
);
  import ptw_pkg::*;

  cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.root_table_address <= ROOT_RESET;
      regs.region_base        <= REGION_BASE_RESET;
      regs.region_mask        <= REGION_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_ROOT_TABLE:  regs.root_table_address <= cfg_data[PA_W-1:0];
        CFG_REGION_BASE: regs.region_base        <= cfg_data;
        CFG_REGION_MASK: regs.region_mask        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ptw_walk.sv
// Walk state and the combinational step that decodes one request or table entry.
module ptw_walk #(
  parameter int LEVELS = ptw_pkg::DEFAULT_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  ptw_pkg::cfg_t     cfg,
  input  ptw_pkg::item_t    item,
  input  logic              fire,
  output logic              has_result,
  output ptw_pkg::result_t  result
);
  import ptw_pkg::*;

  logic                  walk_busy, walk_busy_next;
  logic [LEVEL_W-1:0]    walk_level, walk_level_next;
  logic [PN_W-1:0]       saved_page_number, saved_page_number_next;
  logic [PN_W-1:0]       current_table_base, current_table_base_next;

  logic                  addr_bad;
  logic                  bad;
  logic                  hit;
  result_kind_e          kind;
  fault_e                fault;
  logic [LEVEL_W-1:0]    eff_level;
  logic [PN_W-1:0]       eff_base;
  logic [PN_W-1:0]       eff_pn;
  logic [INDEX_BITS-1:0] eff_index;
  logic [VA_W-1:0]       data;

  assign data = item.read_data;
  assign addr_bad = ((item.virtual_address & cfg.region_mask) != cfg.region_base) ||
                    (item.virtual_address[PAGE_SHIFT-1:0] != '0);

  // Next state and the view of the walk that the result describes
  always_comb begin
    walk_busy_next          = walk_busy;
    walk_level_next         = walk_level;
    saved_page_number_next  = saved_page_number;
    current_table_base_next = current_table_base;
    has_result              = 1'b0;
    bad                     = 1'b0;
    hit                     = 1'b0;
    kind                    = RESULT_LOOKUP_DONE;
    fault                   = FAULT_NONE;
    if (item.kind == ITEM_LOOKUP) begin
      if (!walk_busy) begin
        has_result = 1'b1;
        if (addr_bad) begin
          bad   = 1'b1;
          fault = FAULT_BAD_ADDRESS;
        end else begin
          kind                    = RESULT_READ_REQUEST;
          walk_busy_next          = 1'b1;
          walk_level_next         = LEVEL_W'(1);
          saved_page_number_next  = item.virtual_address[PA_W-1:PAGE_SHIFT];
          current_table_base_next = cfg.root_table_address[PA_W-1:PAGE_SHIFT];
        end
      end
    end else if (walk_busy) begin
      has_result = 1'b1;
      priority if (item.read_error) begin
        fault           = FAULT_READ_ERROR;
        walk_busy_next  = 1'b0;
        walk_level_next = LEVEL_W'(1);
      end else if (!data[DESC_VALID_BIT]) begin
        fault           = FAULT_INVALID_ENTRY;
        walk_busy_next  = 1'b0;
        walk_level_next = LEVEL_W'(1);
      end else if (!data[DESC_TABLE_BIT] || walk_level >= LEVEL_W'(LEVELS)) begin
        hit             = 1'b1;
        walk_busy_next  = 1'b0;
        walk_level_next = LEVEL_W'(1);
      end else begin
        kind                    = RESULT_READ_REQUEST;
        current_table_base_next = data[PA_W-1:PAGE_SHIFT];
        walk_level_next         = walk_level + LEVEL_W'(1);
      end
    end
  end

  // A read request describes the entry about to be read, a finish the entry just read
  always_comb begin
    if (kind == RESULT_READ_REQUEST) begin
      eff_level = walk_level_next;
      eff_base  = current_table_base_next;
      eff_pn    = saved_page_number_next;
    end else begin
      eff_level = walk_level;
      eff_base  = current_table_base;
      eff_pn    = saved_page_number;
    end
    eff_index = '0;
    for (int l = 1; l <= LEVELS; l++) begin
      if (eff_level == LEVEL_W'(l)) begin
        eff_index = eff_pn[INDEX_BITS*(LEVELS-l) +: INDEX_BITS];
      end
    end
  end

  always_comb begin
    result.kind             = kind;
    result.found            = hit;
    result.fault_reason     = fault;
    result.entry_address    = bad ? '0 : {eff_base, eff_index, ENTRY_SHIFT'(0)};
    result.final_level      = bad ? LEVEL_W'(1) : eff_level;
    result.table_index      = bad ? '0 : eff_index;
    result.output_address   = hit ? {data[PA_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)} : '0;
    result.exec_permission  = hit ? data[DESC_XN_LSB +: ATTR_W] : '0;
    result.shareability     = hit ? data[DESC_SH_LSB +: ATTR_W] : '0;
    result.write_permission = hit ? data[DESC_AP_RW_BIT] : 1'b0;
    result.user_access      = hit ? data[DESC_AP_EL_BIT] : 1'b0;
    result.memory_type      = hit ? data[DESC_ATTR_LSB +: ATTR_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy          <= 1'b0;
      walk_level         <= LEVEL_W'(1);
      saved_page_number  <= '0;
      current_table_base <= '0;
    end else if (fire) begin
      walk_busy          <= walk_busy_next;
      walk_level         <= walk_level_next;
      saved_page_number  <= saved_page_number_next;
      current_table_base <= current_table_base_next;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    walk_level >= LEVEL_W'(1) && walk_level <= LEVEL_W'(LEVELS))
    else $error("walk level out of range");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !walk_busy |-> walk_level == LEVEL_W'(1))
    else $error("idle walker not at first level");

  a_descend: assert property (@(posedge clk) disable iff (rst)
    fire && walk_busy && item.kind == ITEM_READ_RESPONSE && kind == RESULT_READ_REQUEST
    |=> walk_busy && walk_level == $past(walk_level) + LEVEL_W'(1))
    else $error("table entry did not descend one level");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && kind == RESULT_LOOKUP_DONE |=> !walk_busy)
    else $error("walker still busy after finishing a lookup");

endmodule

FILE: hw/rtl/page_table_walker.sv
// Top level of the translation table walker: item register, walk step, result register.
//
// Usage:
//  - Item channel (item_valid/item_ready): either a lookup request carrying a virtual
//    address, or the response to a table read carrying one 64-bit entry and an error flag.
//  - Result channel (result_valid/result_ready): either a table read request (entry
//    address, level, index) to be answered on the item channel, or a finished lookup
//    with fault reason, output address and decoded attributes.
//  - Configuration channel (cfg_valid/cfg_ready, always ready): index 0 root table
//    address, 1 region base, 2 region mask; any other index is dropped. Write only
//    while no walk is in flight.
//  - Path: an item taken is held in the item register; the walk step decodes it, and
//    the result register takes its result once the held item advances.
//  - Throughput: one item per cycle while results drain; the whole decode of a request or
//    entry is one pass of mask, compare and concatenation logic between the two registers.
//  - Items that cause nothing (lookup while busy, response while idle) are dropped
//    without touching the result channel.
//  - A stalled receiver holds the result register; the held item waits behind it
//    only if it has a result of its own, so item_ready drops only once both
//    registers are full.
//  - Reset clears the walk, both valid flags and the configuration to its reset values.
module page_table_walker #(
  parameter int LEVELS = ptw_pkg::DEFAULT_LEVELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ptw_pkg::VA_W-1:0]          cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              item_kind,
  input  logic [ptw_pkg::VA_W-1:0]          virtual_address,
  input  logic [ptw_pkg::VA_W-1:0]          read_data,
  input  logic                              read_error,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              result_kind,
  output logic [ptw_pkg::PA_W-1:0]          entry_address,
  output logic                              found,
  output logic [1:0]                        fault_reason,
  output logic [ptw_pkg::LEVEL_W-1:0]       final_level,
  output logic [ptw_pkg::INDEX_BITS-1:0]    table_index,
  output logic [ptw_pkg::PA_W-1:0]          output_address,
  output logic [ptw_pkg::ATTR_W-1:0]        exec_permission,
  output logic [ptw_pkg::ATTR_W-1:0]        shareability,
  output logic                              write_permission,
  output logic                              user_access,
  output logic [ptw_pkg::ATTR_W-1:0]        memory_type
);
  import ptw_pkg::*;

  cfg_t    cfg;
  item_t   held_item;
  logic    held_valid;
  logic    step_has_result;
  result_t step_result;
  result_t res;
  logic    res_valid;
  logic    advance;

  // Configuration is always taken at once
  assign cfg_ready = 1'b1;

  ptw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Consume the held item when it yields nothing, or when the result register frees up
  assign advance    = held_valid && (!step_has_result || !res_valid || result_ready);
  assign item_ready = !held_valid || advance;

  // Item register: load on accept, drop once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= (item_valid && item_ready) || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item.kind            <= item_kind_e'(item_kind);
      held_item.virtual_address <= virtual_address;
      held_item.read_data       <= read_data;
      held_item.read_error      <= read_error;
    end
  end

  ptw_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (held_item),
    .fire       (advance),
    .has_result (step_has_result),
    .result     (step_result)
  );

  // Result register: advance on a new result, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_has_result) begin
      res_valid <= 1'b1;
    end else if (result_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_has_result) begin
      res <= step_result;
    end
  end

  assign result_valid     = res_valid;
  assign result_kind      = res.kind;
  assign entry_address    = res.entry_address;
  assign found            = res.found;
  assign fault_reason     = res.fault_reason;
  assign final_level      = res.final_level;
  assign table_index      = res.table_index;
  assign output_address   = res.output_address;
  assign exec_permission  = res.exec_permission;
  assign shareability     = res.shareability;
  assign write_permission = res.write_permission;
  assign user_access      = res.user_access;
  assign memory_type      = res.memory_type;

endmodule

FILE: verif/tb_page_table_walker.sv
// Self-checking testbench for page_table_walker: directed walks, then random walks checked by a predictor.
module tb_page_table_walker;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam int LEVELS        = DEFAULT_LEVELS;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;     // extra wait after the due results drain
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off, enough to back up the item side
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all before giving up
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 155;

  // Index past the end of the register file: the block must drop the write.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  // How the result side behaves over a stretch of cycles.
  typedef enum int {
    SINK_ALWAYS,
    SINK_HALF,
    SINK_ONE_IN_THREE,
    SINK_MOSTLY
  } sink_mode_e;

  // One row of the directed table. Where typed is set the expectation is taken from the
  // row itself; otherwise the predictor supplies it.
  typedef struct {
    item_kind_e         kind;
    logic [VA_W-1:0]    va;
    logic [VA_W-1:0]    data;
    logic               err;
    bit                 typed;
    bit                 gives;
    result_kind_e       rk;
    logic [PA_W-1:0]    ea;
    fault_e             fr;
    logic [LEVEL_W-1:0] lvl;
    logic [INDEX_BITS-1:0] idx;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [VA_W-1:0]        cfg_data;
  logic                   item_valid;
  logic                   item_ready;
  logic                   item_kind;
  logic [VA_W-1:0]        virtual_address;
  logic [VA_W-1:0]        read_data;
  logic                   read_error;
  logic                   result_valid;
  logic                   result_ready;
  logic                   result_kind;
  logic [PA_W-1:0]        entry_address;
  logic                   found;
  logic [1:0]             fault_reason;
  logic [LEVEL_W-1:0]     final_level;
  logic [INDEX_BITS-1:0]  table_index;
  logic [PA_W-1:0]        output_address;
  logic [ATTR_W-1:0]      exec_permission;
  logic [ATTR_W-1:0]      shareability;
  logic                   write_permission;
  logic                   user_access;
  logic [ATTR_W-1:0]      memory_type;

  // Predictor copy of the registers and of the walk state.
  logic [PA_W-1:0]        root_q;
  logic [VA_W-1:0]        region_base_q;
  logic [VA_W-1:0]        region_mask_q;
  bit                     walker_busy;
  int                     walker_level;
  logic [PN_W-1:0]        walk_page_number;
  logic [PN_W-1:0]        walk_table_base;

  result_t                due_results[$];
  int                     mismatches;
  int                     quiet_cycles;
  int                     burst_left;
  bit                     quiet_sender;
  int                     hold_off_asks;

  // Typed expectation for the item currently on offer (directed table only).
  bit                     typed_now;
  bit                     typed_gives;
  result_t                typed_want;

  page_table_walker #(
    .LEVELS(LEVELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item_kind(item_kind),
    .virtual_address(virtual_address),
    .read_data(read_data),
    .read_error(read_error),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_kind(result_kind),
    .entry_address(entry_address),
    .found(found),
    .fault_reason(fault_reason),
    .final_level(final_level),
    .table_index(table_index),
    .output_address(output_address),
    .exec_permission(exec_permission),
    .shareability(shareability),
    .write_permission(write_permission),
    .user_access(user_access),
    .memory_type(memory_type)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Page aligned address that passes the region check under the current registers.
  function automatic logic [VA_W-1:0] region_hit_address();
    logic [VA_W-1:0] va;
    va = (rand64() & ~region_mask_q) | (region_base_q & region_mask_q);
    va[PAGE_SHIFT-1:0] = '0;
    return va;
  endfunction

  // Step the walk by one accepted item. Returns 1 when the item causes a result.
  function automatic bit predict_walk_step(input item_t it, output result_t res);
    logic [INDEX_BITS-1:0] idx;
    bit                    ends;
    res  = '0;
    ends = 1'b0;
    if (it.kind == ITEM_LOOKUP) begin
      if (walker_busy) return 1'b0;
      if ((it.virtual_address & region_mask_q) != region_base_q ||
          it.virtual_address[PAGE_SHIFT-1:0] != '0) begin
        // Bad address: finish at once, nothing else reported, walker stays idle.
        res.kind         = RESULT_LOOKUP_DONE;
        res.fault_reason = FAULT_BAD_ADDRESS;
        res.final_level  = 3'd1;
        return 1'b1;
      end
      walker_busy      = 1'b1;
      walker_level     = 1;
      walk_page_number = it.virtual_address[PA_W-1:PAGE_SHIFT];
      walk_table_base  = root_q[PA_W-1:PAGE_SHIFT];
    end else begin
      if (!walker_busy) return 1'b0;
      if (!it.read_error && it.read_data[DESC_VALID_BIT] && it.read_data[DESC_TABLE_BIT] &&
          walker_level < LEVELS) begin
        // Table entry: descend one level and ask for the next entry.
        walk_table_base = it.read_data[PA_W-1:PAGE_SHIFT];
        walker_level++;
      end else begin
        ends     = 1'b1;
        res.kind = RESULT_LOOKUP_DONE;
        if (it.read_error) begin
          res.fault_reason = FAULT_READ_ERROR;
        end else if (!it.read_data[DESC_VALID_BIT]) begin
          res.fault_reason = FAULT_INVALID_ENTRY;
        end else begin
          res.found            = 1'b1;
          res.output_address   = {it.read_data[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          res.exec_permission  = it.read_data[DESC_XN_LSB +: ATTR_W];
          res.shareability     = it.read_data[DESC_SH_LSB +: ATTR_W];
          res.write_permission = it.read_data[DESC_AP_RW_BIT];
          res.user_access      = it.read_data[DESC_AP_EL_BIT];
          res.memory_type      = it.read_data[DESC_ATTR_LSB +: ATTR_W];
        end
      end
    end
    idx = INDEX_BITS'(walk_page_number >> (INDEX_BITS * (LEVELS - walker_level)));
    res.entry_address = {walk_table_base, idx, {ENTRY_SHIFT{1'b0}}};
    res.final_level   = LEVEL_W'(walker_level);
    res.table_index   = idx;
    if (ends) begin
      walker_busy  = 1'b0;
      walker_level = 1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one item in bursts with random gaps; hold valid and payload until taken.
  task automatic offer(input item_t it);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(10, 30);
        default:    gap = $urandom_range(1, 5);
      endcase
      if (quiet_sender) gap = 0;
      if (gap != 0) begin
        item_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_valid      = 1'b1;
    item_kind       = it.kind;
    virtual_address = it.virtual_address;
    read_data       = it.read_data;
    read_error      = it.read_error;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [VA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pause the sender until every due result is in and the walker is idle again; close
  // any walk left open with an entry that ends it wherever it stands.
  task automatic settle_walker();
    item_t it;
    bit    again;
    do begin
      item_valid = 1'b0;
      while (due_results.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      again = walker_busy;
      if (again) begin
        it.kind            = ITEM_READ_RESPONSE;
        it.virtual_address = rand64();
        it.read_data       = rand64();
        it.read_error      = 1'($urandom_range(0, 1));
        it.read_data[DESC_TABLE_BIT] = 1'b0;
        offer(it);
      end
    end while (again);
  endtask

  // Result side: switch between stall patterns, and honour a long hold-off on request.
  initial begin
    sink_mode_e mode;
    int         span;
    int         tick;
    int         hold_off_done;
    result_ready  = 1'b0;
    hold_off_done = 0;
    tick          = 0;
    wait (rst === 1'b0);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_off_asks > hold_off_done) begin
          // Hold the result side shut so the block fills and stalls its items.
          result_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_done++;
        end
        case (mode)
          SINK_ALWAYS:       result_ready = 1'b1;
          SINK_HALF:         result_ready = 1'($urandom_range(0, 1));
          SINK_ONE_IN_THREE: result_ready = (tick % 3 == 0);
          default:           result_ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Sample both channels at the rising edge: check results, predict accepted items,
  // track register writes, and watch for a hang.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t predicted;
    item_t   seen;
    bit      gives;
    if (rst) begin
      root_q           = ROOT_RESET;
      region_base_q    = REGION_BASE_RESET;
      region_mask_q    = REGION_MASK_RESET;
      walker_busy      = 1'b0;
      walker_level     = 1;
      walk_page_number = '0;
      walk_table_base  = '0;
      mismatches       = 0;
      quiet_cycles     = 0;
    end else begin
      if (result_valid && result_ready) begin
        got.kind             = result_kind_e'(result_kind);
        got.entry_address    = entry_address;
        got.found            = found;
        got.fault_reason     = fault_e'(fault_reason);
        got.final_level      = final_level;
        got.table_index      = table_index;
        got.output_address   = output_address;
        got.exec_permission  = exec_permission;
        got.shareability     = shareability;
        got.write_permission = write_permission;
        got.user_access      = user_access;
        got.memory_type      = memory_type;
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", 64'(got.entry_address), '0);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
          if (got.entry_address !== want.entry_address)
            report_mismatch("entry_address", 64'(got.entry_address), 64'(want.entry_address));
          if (got.found !== want.found)
            report_mismatch("found", 64'(got.found), 64'(want.found));
          if (got.fault_reason !== want.fault_reason)
            report_mismatch("fault_reason", 64'(got.fault_reason), 64'(want.fault_reason));
          if (got.final_level !== want.final_level)
            report_mismatch("final_level", 64'(got.final_level), 64'(want.final_level));
          if (got.table_index !== want.table_index)
            report_mismatch("table_index", 64'(got.table_index), 64'(want.table_index));
          if (got.output_address !== want.output_address)
            report_mismatch("output_address", 64'(got.output_address),
                            64'(want.output_address));
          if (got.exec_permission !== want.exec_permission)
            report_mismatch("exec_permission", 64'(got.exec_permission),
                            64'(want.exec_permission));
          if (got.shareability !== want.shareability)
            report_mismatch("shareability", 64'(got.shareability), 64'(want.shareability));
          if (got.write_permission !== want.write_permission)
            report_mismatch("write_permission", 64'(got.write_permission),
                            64'(want.write_permission));
          if (got.user_access !== want.user_access)
            report_mismatch("user_access", 64'(got.user_access), 64'(want.user_access));
          if (got.memory_type !== want.memory_type)
            report_mismatch("memory_type", 64'(got.memory_type), 64'(want.memory_type));
        end
      end

      if (item_valid && item_ready) begin
        seen.kind            = item_kind_e'(item_kind);
        seen.virtual_address = virtual_address;
        seen.read_data       = read_data;
        seen.read_error      = read_error;
        // Always step the predictor so its walk state follows the block.
        gives = predict_walk_step(seen, predicted);
        if (typed_now) begin
          if (typed_gives) due_results.push_back(typed_want);
        end else if (gives) begin
          due_results.push_back(predicted);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROOT_TABLE:  root_q        = cfg_data[PA_W-1:0];
          CFG_REGION_BASE: region_base_q = cfg_data;
          CFG_REGION_MASK: region_mask_q = cfg_data;
          default: ;
        endcase
      end

      if ((result_valid && result_ready) || (item_valid && item_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles, %0d results still due",
                 $realtime, STALL_LIMIT, due_results.size());
        $display("[page_table_walker] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t         plan[$];
    item_t             it;
    int                depth;
    int                phase_end;
    int                items_sent;
    logic [VA_W-1:0]   root_v;
    logic [VA_W-1:0]   base_v;
    logic [VA_W-1:0]   mask_v;

    // Drive every input to a known value and hold reset.
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_valid      = 1'b0;
    item_kind       = 1'b0;
    virtual_address = '0;
    read_data       = '0;
    read_error      = 1'b0;

    burst_left       = 0;
    quiet_sender     = 1'b0;
    hold_off_asks    = 0;
    typed_now        = 1'b0;
    typed_gives      = 1'b0;
    typed_want       = '0;
    items_sent       = 0;

    // Directed walks under the reset registers: root 0, base 0, upper 16 bits masked.
    plan = '{
      // response with no walk open: dropped
      '{ITEM_READ_RESPONSE, 64'h0, 64'h3, 1'b0, 1'b1, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // upper bits outside the region, then a non-zero page offset
      '{ITEM_LOOKUP, 64'hFFFF_0000_0000_0000, 64'h0, 1'b0, 1'b1, 1'b1,
        RESULT_LOOKUP_DONE, 48'h0, FAULT_BAD_ADDRESS, 3'd1, 9'd0},
      '{ITEM_LOOKUP, 64'h0000_0000_0000_0FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1,
        RESULT_LOOKUP_DONE, 48'h0, FAULT_BAD_ADDRESS, 3'd1, 9'd0},
      // lowest address: first read at the root, then a lookup while busy is dropped
      '{ITEM_LOOKUP, 64'h0, 64'h0, 1'b0, 1'b1, 1'b1,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd1, 9'd0},
      '{ITEM_LOOKUP, 64'h0000_0000_0000_1000, 64'h0, 1'b0, 1'b1, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // read error wins over an entry that would otherwise be a table
      '{ITEM_READ_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1,
        RESULT_LOOKUP_DONE, 48'h0, FAULT_READ_ERROR, 3'd1, 9'd0},
      // highest in-region address: last entry of the root table, found invalid
      '{ITEM_LOOKUP, 64'h0000_FFFF_FFFF_F000, 64'h0, 1'b0, 1'b1, 1'b1,
        RESULT_READ_REQUEST, 48'hFF8, FAULT_NONE, 3'd1, 9'd511},
      '{ITEM_READ_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, 1'b1,
        RESULT_LOOKUP_DONE, 48'hFF8, FAULT_INVALID_ENTRY, 3'd1, 9'd511},
      // full four-level walk ending on a page with every attribute bit set
      '{ITEM_LOOKUP, 64'h0000_FFFF_FFFF_F000, 64'h0, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_FFFF_FFFF_F003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_FFFF_FFFF_F003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_FFFF_FFFF_F003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // block straight from the root table
      '{ITEM_LOOKUP, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0060_0000_4000_03C5, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // block at level 2 with every attribute clear
      '{ITEM_LOOKUP, 64'h0000_0000_0000_1000, 64'h0, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h3, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h1, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // table bit without the valid bit at level 2
      '{ITEM_LOOKUP, 64'h0000_8000_0000_0000, 64'h0, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_8000_0000_0003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h2, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      // read error part way down, at level 3
      '{ITEM_LOOKUP, 64'h0000_0000_4020_1000, 64'h0, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_0000_0001_0003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0000_0000_0002_0003, 1'b0, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0},
      '{ITEM_READ_RESPONSE, 64'h0, 64'h0, 1'b1, 1'b0, 1'b0,
        RESULT_READ_REQUEST, 48'h0, FAULT_NONE, 3'd0, 9'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      typed_now                = plan[i].typed;
      typed_gives              = plan[i].gives;
      typed_want               = '0;
      typed_want.kind          = plan[i].rk;
      typed_want.entry_address = plan[i].ea;
      typed_want.fault_reason  = plan[i].fr;
      typed_want.final_level   = plan[i].lvl;
      typed_want.table_index   = plan[i].idx;
      it.kind            = plan[i].kind;
      it.virtual_address = plan[i].va;
      it.read_data       = plan[i].data;
      it.read_error      = plan[i].err;
      offer(it);
    end
    typed_now = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      // Registers change only with the walker idle and nothing in flight.
      settle_walker();
      case (phase)
        0: begin
          // open region: any page aligned address passes
          root_v = '1;
          base_v = '0;
          mask_v = '0;
        end
        1: begin
          // every bit compared: only one page passes
          root_v = '0;
          mask_v = '1;
          base_v = rand64() & ~64'hFFF;
        end
        2: begin
          root_v = rand64();
          mask_v = 64'hFFFF_0000_0000_0000;
          base_v = 64'hFFFF_0000_0000_0000;
        end
        default: begin
          root_v = rand64();
          mask_v = rand64();
          base_v = rand64() & mask_v & ~64'hFFF;
        end
      endcase
      write_reg(CFG_ROOT_TABLE, root_v);
      write_reg(CFG_REGION_MASK, mask_v);
      write_reg(CFG_REGION_BASE, base_v);
      if (phase == 3) write_reg(CFG_SPARE, rand64());

      // One phase with a sender that never idles; two with a long receiver hold-off.
      quiet_sender = (phase == 1);
      if (phase == 2 || phase == 4) hold_off_asks++;

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed walk: tables down to a chosen depth, then a terminal entry.
          depth              = $urandom_range(1, LEVELS);
          it.kind            = ITEM_LOOKUP;
          it.virtual_address = region_hit_address();
          it.read_data       = rand64();
          it.read_error      = 1'($urandom_range(0, 1));
          offer(it);
          items_sent++;
          for (int lvl = 1; lvl <= depth; lvl++) begin
            if ($urandom_range(0, 11) == 0) begin
              // stray lookup in the middle of a walk: dropped
              it.kind            = ITEM_LOOKUP;
              it.virtual_address = region_hit_address();
              offer(it);
              items_sent++;
            end
            it.kind            = ITEM_READ_RESPONSE;
            it.virtual_address = rand64();
            it.read_data       = rand64();
            it.read_error      = 1'b0;
            if (lvl < depth) begin
              it.read_data[1:0] = 2'b11;
            end else begin
              case ($urandom_range(0, 9))
                0:       it.read_error = 1'b1;
                1:       it.read_data[DESC_VALID_BIT] = 1'b0;
                2, 3, 4: it.read_data[1:0] = (lvl == LEVELS) ? 2'b11 : 2'b01;
                default: it.read_data[1:0] = 2'b01;
              endcase
            end
            offer(it);
            items_sent++;
          end
        end else begin
          // Noise: random or misaligned lookups and unsolicited responses.
          it.virtual_address = rand64();
          it.read_data       = rand64();
          it.read_error      = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 2))
            0: it.kind = ITEM_LOOKUP;
            1: begin
              it.kind            = ITEM_LOOKUP;
              it.virtual_address = region_hit_address();
              it.virtual_address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, 4095));
            end
            default: it.kind = ITEM_READ_RESPONSE;
          endcase
          offer(it);
          items_sent++;
        end
      end
    end

    settle_walker();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[page_table_walker] OK");
    end else begin
      $display("[page_table_walker] ERROR");
    end
    $finish;
  end

endmodule
